### src/rmq_pkg.sv
// rmq_pkg: shared widths, constants, codes and saturation helpers for the
// rotation matrix to quaternion block. No dependencies.
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int DW        = 16;                     // element and component width
	// radicand: one plus up to three elements, always positive when used
	localparam int RW        = (FRAC_BITS >= DW) ? FRAC_BITS + 2 : DW + 1;
	localparam int CW        = RW + 2;                  // signed classify math
	localparam int NW        = DW + 2;                  // signed numerator
	localparam int MAGW      = NW - 1;                  // numerator magnitude
	localparam int SQIW      = RW + FRAC_BITS;          // root operand
	localparam int ROOTW     = (SQIW + 1) / 2;          // root result, one bit per stage
	localparam int DENW      = ROOTW + 2;               // divisor 2*S
	localparam int NUMW      = MAGW + FRAC_BITS + 2;    // dividend (mag << F+1) + S
	localparam int QW        = FRAC_BITS + 2;           // quotient bits, one per stage
	localparam int FQD       = 4;                       // front to back queue depth
	localparam int FQAW      = 2;
	localparam int OQD       = 2;                       // result queue depth
	localparam int OQAW      = 1;

	localparam longint ONE     = 64'sd1 << FRAC_BITS;
	localparam longint EPS     = (ONE + 5000) / 10000;
	localparam longint ID_LIM  = 3 * ONE - EPS;
	localparam longint SAT_HI  = (ONE < 32767) ? ONE : 32767;
	localparam longint SAT_LOM = (ONE < 32768) ? ONE : 32768;

	typedef enum logic [2:0] {
		BR_IDENT = 3'd0,
		BR_TRACE = 3'd1,
		BR_X     = 3'd2,
		BR_Y     = 3'd3,
		BR_Z     = 3'd4,
		BR_DEGEN = 3'd5
	} br_t;

	// which component comes from the root
	typedef enum logic [1:0] {
		SL_X = 2'd0,
		SL_Y = 2'd1,
		SL_Z = 2'd2,
		SL_W = 2'd3
	} slot_t;

	typedef struct packed {
		br_t                     code;
		slot_t                   maj;
		logic [RW-1:0]           rad;
		logic signed [NW-1:0]    n0;
		logic signed [NW-1:0]    n1;
		logic signed [NW-1:0]    n2;
	} cls_t;

	typedef struct packed {
		br_t                     code;
		slot_t                   maj;
		logic signed [NW-1:0]    n0;
		logic signed [NW-1:0]    n1;
		logic signed [NW-1:0]    n2;
	} sba_t;

	typedef struct packed {
		br_t                     code;
		slot_t                   maj;
		logic [2:0]              neg;
		logic signed [DW-1:0]    quart;
	} sbb_t;

	typedef struct packed {
		logic signed [DW-1:0]    x;
		logic signed [DW-1:0]    y;
		logic signed [DW-1:0]    z;
		logic signed [DW-1:0]    w;
		br_t                     code;
	} res_t;

	// signed, saturated quotient from magnitude, overflow flag and sign
	function automatic logic signed [DW-1:0] sat_quot(logic [QW-1:0] q, logic ovf,
		logic neg);
		logic [QW:0]          lim;
		logic [QW:0]          mag;
		logic signed [QW+1:0] sv;
		lim = neg ? (QW+1)'(SAT_LOM) : (QW+1)'(SAT_HI);
		mag = (ovf || ({1'b0, q} > lim)) ? lim : {1'b0, q};
		sv  = {1'b0, mag};
		if (neg)
			sv = -sv;
		return DW'(sv);
	endfunction

	// quarter of 2*sqrt is the root halved, then clamped
	function automatic logic signed [DW-1:0] sat_root(logic [ROOTW-1:0] r);
		logic [ROOTW:0] h;
		h = {2'b00, r[ROOTW-1:1]};
		if (h > (ROOTW+1)'(SAT_HI))
			h = (ROOTW+1)'(SAT_HI);
		return DW'(h);
	endfunction

endpackage

### src/rmq_front.sv
// rmq_front: trace, branch choice, radicand and numerators per matrix,
// written into a short queue toward the back end. Depends on rmq_pkg.
module rmq_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [rmq_pkg::DW-1:0] m00,
	input  logic signed [rmq_pkg::DW-1:0] m01,
	input  logic signed [rmq_pkg::DW-1:0] m02,
	input  logic signed [rmq_pkg::DW-1:0] m10,
	input  logic signed [rmq_pkg::DW-1:0] m11,
	input  logic signed [rmq_pkg::DW-1:0] m12,
	input  logic signed [rmq_pkg::DW-1:0] m20,
	input  logic signed [rmq_pkg::DW-1:0] m21,
	input  logic signed [rmq_pkg::DW-1:0] m22,
	output logic                         cls_valid,
	output rmq_pkg::cls_t                cls_head,
	input  logic                         cls_pop
);
	import rmq_pkg::*;

	localparam logic signed [CW-1:0] ONE_C = CW'(ONE);
	localparam logic signed [CW-1:0] EPS_C = CW'(EPS);
	localparam logic signed [CW-1:0] ID_C  = CW'(ID_LIM);

	logic signed [CW-1:0] e00, e11, e22, tr, rad_tr, rad_x, rad_y, rad_z, rad_m;
	logic                 x_maj, y_maj;
	cls_t                 cls;

	cls_t                 fq_q [FQD];
	logic [FQAW-1:0]      wptr_q, rptr_q;
	logic [FQAW:0]        cnt_q;
	logic                 wr, rd;

	assign e00    = CW'(m00);
	assign e11    = CW'(m11);
	assign e22    = CW'(m22);
	assign tr     = e00 + e11 + e22;
	assign rad_tr = tr + ONE_C;
	assign rad_x  = ONE_C + e00 - e11 - e22;
	assign rad_y  = ONE_C + e11 - e00 - e22;
	assign rad_z  = ONE_C + e22 - e00 - e11;
	assign x_maj  = (m00 > m11) && (m00 > m22);
	assign y_maj  = m11 > m22;

	always_comb begin
		cls.code = BR_IDENT;
		cls.maj  = SL_W;
		cls.rad  = '0;
		cls.n0   = NW'(m21) - NW'(m12);
		cls.n1   = NW'(m02) - NW'(m20);
		cls.n2   = NW'(m10) - NW'(m01);
		rad_m    = rad_tr;
		if (tr > ID_C) begin
			cls.code = BR_IDENT;
		end else if (rad_tr > EPS_C) begin
			cls.code = BR_TRACE;
		end else if (x_maj) begin
			cls.code = BR_X;
			cls.maj  = SL_X;
			rad_m    = rad_x;
			cls.n0   = NW'(m01) + NW'(m10);
			cls.n1   = NW'(m02) + NW'(m20);
			cls.n2   = NW'(m21) - NW'(m12);
		end else if (y_maj) begin
			cls.code = BR_Y;
			cls.maj  = SL_Y;
			rad_m    = rad_y;
			cls.n0   = NW'(m01) + NW'(m10);
			cls.n1   = NW'(m12) + NW'(m21);
			cls.n2   = NW'(m02) - NW'(m20);
		end else begin
			cls.code = BR_Z;
			cls.maj  = SL_Z;
			rad_m    = rad_z;
			cls.n0   = NW'(m02) + NW'(m20);
			cls.n1   = NW'(m12) + NW'(m21);
			cls.n2   = NW'(m10) - NW'(m01);
		end
		if (cls.code != BR_IDENT) begin
			if (rad_m <= CW'(0))
				cls.code = BR_DEGEN;
			else
				cls.rad = rad_m[RW-1:0];
		end
	end

	assign full      = (cnt_q == (FQAW+1)'(FQD));
	assign wr        = push && !full;
	assign cls_valid = (cnt_q != '0);
	assign rd        = cls_pop && cls_valid;
	assign cls_head  = fq_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			fq_q[wptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (rd)
				rptr_q <= rptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### src/rmq_sqrt.sv
// rmq_sqrt: pipelined integer square root of rad << FRAC_BITS, one result
// bit per stage. Depends on rmq_pkg.
module rmq_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [rmq_pkg::RW-1:0]      rad,
	output logic [rmq_pkg::ROOTW-1:0]   root
);
	import rmq_pkg::*;

	localparam int VW = 2 * ROOTW;

	logic [VW-1:0]    rem_s  [ROOTW];
	logic [ROOTW-1:0] root_s [ROOTW];
	logic [VW-1:0]    v0;

	assign v0   = VW'(rad) << FRAC_BITS;
	assign root = root_s[ROOTW-1];

	for (genvar k = 0; k < ROOTW; k++) begin : g_stage
		localparam int B = ROOTW - 1 - k;
		logic [VW-1:0]    rem_in, trial;
		logic [ROOTW-1:0] root_in;
		if (k == 0) begin : g_first
			assign rem_in  = v0;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end
		assign trial = (VW'(root_in) << (B + 1)) + (VW'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k]  <= rem_in - trial;
					root_s[k] <= root_in | (ROOTW'(1) << B);
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in;
				end
			end
		end
	end

endmodule

### src/rmq_div.sv
// rmq_div: pipelined restoring divider lane, one quotient bit per stage,
// with an overflow flag for quotients past the bit range. Depends on rmq_pkg.
module rmq_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rmq_pkg::NUMW-1:0]   num,
	input  logic [rmq_pkg::DENW-1:0]   den,
	output logic [rmq_pkg::QW-1:0]     quot,
	output logic                       ovf
);
	import rmq_pkg::*;

	localparam int DCW = (DENW + QW > NUMW) ? DENW + QW : NUMW;

	logic [DCW-1:0]  rem_s [QW];
	logic [DENW-1:0] den_s [QW];
	logic [QW-1:0]   q_s   [QW];
	logic            ovf_s [QW];

	assign quot = q_s[QW-1];
	assign ovf  = ovf_s[QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic [DCW-1:0]  rem_in, sub;
		logic [DENW-1:0] den_in;
		logic [QW-1:0]   q_in;
		logic            ovf_in;
		if (k == 0) begin : g_first
			assign rem_in = DCW'(num);
			assign den_in = den;
			assign q_in   = '0;
			assign ovf_in = DCW'(num) >= (DCW'(den) << QW);
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
			assign ovf_in = ovf_s[k-1];
		end
		assign sub = DCW'(den_in) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_in;
				ovf_s[k] <= ovf_in;
				if (rem_in >= sub) begin
					rem_s[k] <= rem_in - sub;
					q_s[k]   <= q_in | (QW'(1) << B);
				end else begin
					rem_s[k] <= rem_in;
					q_s[k]   <= q_in;
				end
			end
		end
	end

endmodule

### src/rmq_back.sv
// rmq_back: root pipeline, dividend setup, three divider lanes, component
// placement and the result queue. Depends on rmq_pkg, rmq_sqrt, rmq_div.
module rmq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cls_valid,
	input  rmq_pkg::cls_t cls_head,
	output logic          cls_pop,
	output logic          empty,
	input  logic          pop,
	output rmq_pkg::res_t res
);
	import rmq_pkg::*;

	logic                adv, v_last, oq_full, wr, rd;
	logic [ROOTW-1:0]    va_s;
	sba_t                sba_s [ROOTW];
	logic [ROOTW-1:0]    root;

	logic                vp_s;
	sbb_t                sbp_s;
	logic [NUMW-1:0]     num_sp [3];
	logic [DENW-1:0]     den_sp;
	logic [MAGW-1:0]     mag [3];
	logic signed [NW-1:0] nsel [3];
	sbb_t                sbp_d;

	logic [QW-1:0]       vb_s;
	sbb_t                sbb_s [QW];
	logic [QW-1:0]       quot [3];
	logic                ovf [3];
	logic signed [DW-1:0] lane [3];
	sbb_t                sb_l;
	res_t                res_d;

	res_t                oq_q [OQD];
	logic [OQAW-1:0]     wptr_q, rptr_q;
	logic [OQAW:0]       cnt_q;

	assign v_last  = vb_s[QW-1];
	assign oq_full = (cnt_q == (OQAW+1)'(OQD));
	assign adv     = !(v_last && oq_full);
	assign cls_pop = adv && cls_valid;

	rmq_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (cls_head.rad),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sba_s[0] <= '{code: cls_head.code, maj: cls_head.maj,
				n0: cls_head.n0, n1: cls_head.n1, n2: cls_head.n2};
			for (int k = 1; k < ROOTW; k++)
				sba_s[k] <= sba_s[k-1];
		end
	end

	// dividend and divisor setup behind the root
	assign nsel[0] = sba_s[ROOTW-1].n0;
	assign nsel[1] = sba_s[ROOTW-1].n1;
	assign nsel[2] = sba_s[ROOTW-1].n2;

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag[i] = MAGW'(nsel[i][NW-1] ? -nsel[i] : nsel[i]);
		sbp_d.code  = sba_s[ROOTW-1].code;
		sbp_d.maj   = sba_s[ROOTW-1].maj;
		sbp_d.neg   = {nsel[2][NW-1], nsel[1][NW-1], nsel[0][NW-1]};
		sbp_d.quart = sat_root(root);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sbp_s  <= sbp_d;
			den_sp <= {root, 2'b00};
			for (int i = 0; i < 3; i++)
				num_sp[i] <= (NUMW'(mag[i]) << (FRAC_BITS + 1)) + NUMW'({root, 1'b0});
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		rmq_div u_div (
			.clk  (clk),
			.en   (adv),
			.num  (num_sp[i]),
			.den  (den_sp),
			.quot (quot[i]),
			.ovf  (ovf[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sbb_s[0] <= sbp_s;
			for (int k = 1; k < QW; k++)
				sbb_s[k] <= sbb_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s <= '0;
			vp_s <= 1'b0;
			vb_s <= '0;
		end else if (adv) begin
			va_s <= {va_s[ROOTW-2:0], cls_valid};
			vp_s <= va_s[ROOTW-1];
			vb_s <= {vb_s[QW-2:0], vp_s};
		end
	end

	// component placement
	assign sb_l = sbb_s[QW-1];
	always_comb begin
		for (int i = 0; i < 3; i++)
			lane[i] = sat_quot(quot[i], ovf[i], sb_l.neg[i]);
		res_d.code = sb_l.code;
		res_d.x    = lane[0];
		res_d.y    = lane[1];
		res_d.z    = lane[2];
		res_d.w    = sb_l.quart;
		if ((sb_l.code == BR_IDENT) || (sb_l.code == BR_DEGEN)) begin
			res_d.x = '0;
			res_d.y = '0;
			res_d.z = '0;
			res_d.w = DW'(SAT_HI);
		end else begin
			unique case (sb_l.maj)
				SL_X: begin
					res_d.x = sb_l.quart;
					res_d.y = lane[0];
					res_d.z = lane[1];
					res_d.w = lane[2];
				end
				SL_Y: begin
					res_d.y = sb_l.quart;
					res_d.z = lane[1];
					res_d.w = lane[2];
				end
				SL_Z: begin
					res_d.z = sb_l.quart;
					res_d.w = lane[2];
				end
				default: begin
					res_d.w = sb_l.quart;
				end
			endcase
		end
	end

	// result queue
	assign wr    = adv && v_last;
	assign empty = (cnt_q == '0);
	assign rd    = pop && !empty;
	assign res   = oq_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			oq_q[wptr_q] <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (rd)
				rptr_q <= rptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### src/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: top level, front classifier feeding the
// root and divider back end. Depends on rmq_pkg, rmq_front, rmq_back.
//
// Converts a 3x3 rotation matrix in signed Q1.14 to the unit quaternion
// (x, y, z, w) in Q1.14 by Shepperd's method, with a code for the branch
// taken (identity, trace, x-, y-, z-major, degenerate fallback). Both sides
// are queues: a matrix transfers on push while full is low, a result
// transfers on pop while empty is low, and results leave in input order.
// One matrix is taken per cycle and one result delivered per cycle when the
// consumer keeps up. Between push and a result showing on the outputs lie
// the front queue, the 16-stage square root, one dividend setup stage and
// the 16-stage divider lanes, whose last stage writes the result queue.
// The front holds up to four classified matrices, so it keeps accepting
// while the back end is stalled by a full result queue; full rises only
// once that buffer is used up. Quotients saturate to plus or minus one.
module rotation_matrix_to_quaternion (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [rmq_pkg::DW-1:0] m00,
	input  logic signed [rmq_pkg::DW-1:0] m01,
	input  logic signed [rmq_pkg::DW-1:0] m02,
	input  logic signed [rmq_pkg::DW-1:0] m10,
	input  logic signed [rmq_pkg::DW-1:0] m11,
	input  logic signed [rmq_pkg::DW-1:0] m12,
	input  logic signed [rmq_pkg::DW-1:0] m20,
	input  logic signed [rmq_pkg::DW-1:0] m21,
	input  logic signed [rmq_pkg::DW-1:0] m22,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [rmq_pkg::DW-1:0] quat_x,
	output logic signed [rmq_pkg::DW-1:0] quat_y,
	output logic signed [rmq_pkg::DW-1:0] quat_z,
	output logic signed [rmq_pkg::DW-1:0] quat_w,
	output logic [2:0]                    branch_taken
);
	import rmq_pkg::*;

	// classified matrices waiting for the back end
	logic cls_valid, cls_pop;
	cls_t cls_head;
	res_t res;

	rmq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.m00       (m00),
		.m01       (m01),
		.m02       (m02),
		.m10       (m10),
		.m11       (m11),
		.m12       (m12),
		.m20       (m20),
		.m21       (m21),
		.m22       (m22),
		.cls_valid (cls_valid),
		.cls_head  (cls_head),
		.cls_pop   (cls_pop)
	);

	// root, divides and the result queue
	rmq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid),
		.cls_head  (cls_head),
		.cls_pop   (cls_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign quat_x       = res.x;
	assign quat_y       = res.y;
	assign quat_z       = res.z;
	assign quat_w       = res.w;
	assign branch_taken = res.code;

`ifndef SYNTH
	// identity and fallback results carry the fixed quaternion
	a_ident_value: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (res.code == BR_IDENT || res.code == BR_DEGEN)) |->
		(quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == DW'(SAT_HI)))
		else $error("identity result has wrong components");

	// the root-derived component is never negative
	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.code == BR_TRACE) |-> !quat_w[DW-1])
		else $error("trace branch gave negative w");

	a_xmaj_x_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.code == BR_X) |-> !quat_x[DW-1])
		else $error("x-major branch gave negative x");

	// the back end only drains the front queue when it holds something
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cls_pop |-> cls_valid)
		else $error("front queue popped while empty");
`endif

endmodule
